/* rtl/core/bss_pkg.sv */
// Package with the shared types, codes and reset values of the balance safety supervisor.
`timescale 1ns / 1ps

package bss_pkg;

  localparam int NumWheelsDefault = 2;

  localparam int AddrW = 5;
  localparam int DataW = 32;

  localparam int StepW = 24;

  typedef enum logic [1:0] {
    KIND_EVAL  = 2'd0,
    KIND_LIMIT = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_LATCH_ENABLE = 3'd0,
    REG_FALL_ANGLE   = 3'd1,
    REG_FALL_HOLD    = 3'd2,
    REG_IMU_TIMEOUT  = 3'd3,
    REG_CMD_TIMEOUT  = 3'd4,
    REG_EFFORT_LIM   = 3'd5,
    REG_SLEW_LIM     = 3'd6
  } reg_idx_t;

  localparam int FaultImu  = 0;
  localparam int FaultFall = 1;
  localparam int FaultCmd  = 2;

  localparam logic        LatchEnableRst  = 1'b0;
  localparam logic [14:0] FallAngleRst    = 15'd2867;
  localparam logic [15:0] FallHoldRst     = 16'd200;
  localparam logic [15:0] ImuTimeoutRst   = 16'd50;
  localparam logic [15:0] CmdTimeoutRst   = 16'd500;
  localparam logic [14:0] MaxEffortRst    = 15'd32767;
  localparam logic [23:0] MaxSlewRst      = 24'd16777215;

  typedef struct packed {
    logic        latch_enable;
    logic [14:0] fall_angle;
    logic [15:0] fall_hold;
    logic [15:0] imu_timeout;
    logic [15:0] cmd_timeout;
    logic [14:0] effort_lim;
    logic [23:0] slew_lim;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      now_ms;
    logic             wheel;
    logic [15:0]      desired;
    logic             imu_fail;
    logic             cmd_late;
    logic             tilt;
    logic [StepW-1:0] step;
  } item_t;

endpackage

/* rtl/core/bss_regs.sv */
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module bss_regs (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [bss_pkg::AddrW-1:0] paddr,
  input  logic [bss_pkg::DataW-1:0] pwdata,
  output logic [bss_pkg::DataW-1:0] prdata,
  output logic                 pready,
  output bss_pkg::cfg_t        cfg,
  output logic                 latch_clr
);
  import bss_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);

  assign latch_clr = wr_en && (idx == REG_LATCH_ENABLE) && !pwdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.latch_enable <= LatchEnableRst;
      cfg.fall_angle   <= FallAngleRst;
      cfg.fall_hold    <= FallHoldRst;
      cfg.imu_timeout  <= ImuTimeoutRst;
      cfg.cmd_timeout  <= CmdTimeoutRst;
      cfg.effort_lim   <= MaxEffortRst;
      cfg.slew_lim     <= MaxSlewRst;
    end else if (wr_en) begin
      case (idx)
        REG_LATCH_ENABLE: cfg.latch_enable <= pwdata[0];
        REG_FALL_ANGLE:   cfg.fall_angle   <= pwdata[14:0];
        REG_FALL_HOLD:    cfg.fall_hold    <= pwdata[15:0];
        REG_IMU_TIMEOUT:  cfg.imu_timeout  <= pwdata[15:0];
        REG_CMD_TIMEOUT:  cfg.cmd_timeout  <= pwdata[15:0];
        REG_EFFORT_LIM:   cfg.effort_lim   <= pwdata[14:0];
        REG_SLEW_LIM:     cfg.slew_lim     <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_LATCH_ENABLE: prdata = DataW'(cfg.latch_enable);
      REG_FALL_ANGLE:   prdata = DataW'(cfg.fall_angle);
      REG_FALL_HOLD:    prdata = DataW'(cfg.fall_hold);
      REG_IMU_TIMEOUT:  prdata = DataW'(cfg.imu_timeout);
      REG_CMD_TIMEOUT:  prdata = DataW'(cfg.cmd_timeout);
      REG_EFFORT_LIM:   prdata = DataW'(cfg.effort_lim);
      REG_SLEW_LIM:     prdata = DataW'(cfg.slew_lim);
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/core/bss_prep.sv */
// Input register stage that also precomputes ages, tilt and the slew step.
`timescale 1ns / 1ps

module bss_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     kind,
  input  logic [15:0]    pitch,
  input  logic           imu_ok,
  input  logic [31:0]    now_ms,
  input  logic [31:0]    imu_stamp,
  input  logic [31:0]    cmd_stamp,
  input  logic           wheel,
  input  logic [15:0]    desired,
  input  logic [15:0]    dt,
  input  bss_pkg::cfg_t  cfg,
  input  logic           down_ready,
  output logic           item_valid,
  output bss_pkg::item_t item
);
  import bss_pkg::*;

  logic [16:0] pitch_x;
  logic [16:0] mag;
  logic [31:0] imu_age;
  logic [31:0] cmd_age;
  logic [39:0] prod;
  item_t       item_next;

  assign in_ready = !item_valid || down_ready;

  always_comb begin
    pitch_x = {pitch[15], pitch};
    mag     = pitch[15] ? 17'(-pitch_x) : pitch_x;
    imu_age = now_ms - imu_stamp;
    cmd_age = now_ms - cmd_stamp;
    prod    = 40'(cfg.slew_lim) * 40'(dt);

    item_next.kind     = kind;
    item_next.now_ms   = now_ms;
    item_next.wheel    = wheel;
    item_next.desired  = desired;
    item_next.imu_fail = !imu_ok || (!imu_age[31] && (imu_age > 32'(cfg.imu_timeout)));
    item_next.cmd_late = (cmd_stamp != '0) && !cmd_age[31]
                         && (cmd_age > 32'(cfg.cmd_timeout));
    item_next.tilt     = mag > 17'(cfg.fall_angle);
    item_next.step     = prod[39:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

/* rtl/core/bss_eval.sv */
// Fault evaluation, effort limiting, supervisor state and the result register.
`timescale 1ns / 1ps

module bss_eval #(
  parameter int NUM_WHEELS = bss_pkg::NumWheelsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  bss_pkg::cfg_t  cfg,
  input  logic           latch_clr,
  input  logic           item_valid,
  input  bss_pkg::item_t item,
  output logic           down_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     fault_flags,
  output logic [15:0]    out_effort
);
  import bss_pkg::*;

  logic [2:0]  fault_now;
  logic [2:0]  fault_now_next;
  logic [1:0]  latched;
  logic [1:0]  latched_next;
  logic        fall_timing;
  logic        fall_timing_next;
  logic [31:0] fall_start;
  logic [31:0] fall_start_next;
  logic [15:0] last_output [NUM_WHEELS];
  logic [15:0] last_output_next [NUM_WHEELS];
  logic [15:0] effort_next;

  logic               go;
  logic [2:0]         f;
  logic [31:0]        fall_age;
  logic               in_range;
  logic [15:0]        last;
  logic signed [16:0] want;
  logic signed [16:0] lim;
  logic signed [16:0] clamped;
  logic signed [24:0] delta;
  logic signed [24:0] step_s;
  logic signed [24:0] last_w;

  assign down_ready = !out_valid || out_ready;
  assign go         = item_valid && down_ready;

  always_comb begin
    fault_now_next   = fault_now;
    latched_next     = latch_clr ? 2'b00 : latched;
    fall_timing_next = fall_timing;
    fall_start_next  = fall_start;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      last_output_next[i] = last_output[i];
    end
    effort_next = '0;

    f        = '0;
    fall_age = item.now_ms - fall_start;
    in_range = int'(item.wheel) < NUM_WHEELS;
    last     = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (int'(item.wheel) == i) begin
        last = last_output[i];
      end
    end

    want    = $signed({item.desired[15], item.desired});
    lim     = $signed({2'b00, cfg.effort_lim});
    if (want > lim) begin
      clamped = lim;
    end else if (want < -lim) begin
      clamped = -lim;
    end else begin
      clamped = want;
    end
    step_s = $signed({1'b0, item.step});
    last_w = $signed({{9{last[15]}}, last});
    delta  = $signed({{8{clamped[16]}}, clamped}) - last_w;

    if (go) begin
      case (item.kind)
        KIND_EVAL: begin
          f[FaultImu] = item.imu_fail;
          if (item.tilt) begin
            if (!fall_timing) begin
              fall_timing_next = 1'b1;
              fall_start_next  = item.now_ms;
            end else if (!fall_age[31] && (fall_age >= 32'(cfg.fall_hold))) begin
              f[FaultFall] = 1'b1;
            end
          end else begin
            fall_timing_next = 1'b0;
          end
          f[FaultCmd] = item.cmd_late;
          if (cfg.latch_enable) begin
            latched_next = latched | f[1:0];
            f[1:0]       = f[1:0] | latched_next;
          end
          fault_now_next = f;
        end
        KIND_LIMIT: begin
          if (in_range) begin
            if (fault_now[FaultImu] || fault_now[FaultFall]) begin
              effort_next = '0;
            end else if (delta > step_s) begin
              effort_next = 16'(last_w + step_s);
            end else if (delta < -step_s) begin
              effort_next = 16'(last_w - step_s);
            end else begin
              effort_next = clamped[15:0];
            end
            for (int i = 0; i < NUM_WHEELS; i++) begin
              if (int'(item.wheel) == i) begin
                last_output_next[i] = effort_next;
              end
            end
          end
        end
        KIND_CLEAR: begin
          latched_next     = 2'b00;
          fall_timing_next = 1'b0;
          for (int i = 0; i < NUM_WHEELS; i++) begin
            last_output_next[i] = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_now   <= '0;
      latched     <= '0;
      fall_timing <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        last_output[i] <= '0;
      end
    end else begin
      fault_now   <= fault_now_next;
      latched     <= latched_next;
      fall_timing <= fall_timing_next;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        last_output[i] <= last_output_next[i];
      end
      if (down_ready) begin
        out_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    fall_start <= fall_start_next;
    if (go) begin
      fault_flags <= fault_now_next;
      out_effort  <= effort_next;
    end
  end

endmodule

/* rtl/core/balance_safety_supervisor_top.sv */
// Top level of the balance safety supervisor.
//
//   Channel   Direction  Handshake           Payload
//   input     in         in_valid/in_ready   kind pitch imu_ok now_ms imu_stamp cmd_stamp
//                                            wheel desired dt
//   result    out        out_valid/out_ready fault_flags out_effort
//   config    in         APB psel/penable    paddr pwdata prdata pready
//
// Each transfer goes from input to result through the input register, where ages, tilt
// and the slew step product are formed, and then through fault and limit logic into the
// result register. A new input transfer is taken every cycle while results drain.
// Synchronous reset clears control state and the supervisor state; no clearing pass.
// When out_ready is low the result is held and the input register holds one more item.
`timescale 1ns / 1ps

module balance_safety_supervisor_top #(
  parameter int NUM_WHEELS = bss_pkg::NumWheelsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [15:0] pitch,
  input  logic        imu_ok,
  input  logic [31:0] now_ms,
  input  logic [31:0] imu_stamp,
  input  logic [31:0] cmd_stamp,
  input  logic        wheel,
  input  logic [15:0] desired,
  input  logic [15:0] dt,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  fault_flags,
  output logic [15:0] out_effort,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [bss_pkg::AddrW-1:0] paddr,
  input  logic [bss_pkg::DataW-1:0] pwdata,
  output logic [bss_pkg::DataW-1:0] prdata,
  output logic        pready
);
  import bss_pkg::*;

  cfg_t  cfg;
  logic  latch_clr;
  logic  down_ready;
  logic  item_valid;
  item_t item;

  bss_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .latch_clr (latch_clr)
  );

  bss_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .pitch      (pitch),
    .imu_ok     (imu_ok),
    .now_ms     (now_ms),
    .imu_stamp  (imu_stamp),
    .cmd_stamp  (cmd_stamp),
    .wheel      (wheel),
    .desired    (desired),
    .dt         (dt),
    .cfg        (cfg),
    .down_ready (down_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  bss_eval #(
    .NUM_WHEELS (NUM_WHEELS)
  ) u_eval (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .latch_clr   (latch_clr),
    .item_valid  (item_valid),
    .item        (item),
    .down_ready  (down_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .fault_flags (fault_flags),
    .out_effort  (out_effort)
  );

endmodule
